// ===== design/fra_pkg.sv =====
// Shared types and codes for the handle allocator.
`timescale 1ns / 1ps
package fra_pkg;

    localparam int HANDLE_W = 8;
    localparam int HANDLE_SPACE = 256;
    localparam int COUNT_W = 9;

    localparam logic [1:0] CMD_ALLOC = 2'd0;
    localparam logic [1:0] CMD_TRY_ALLOC = 2'd1;
    localparam logic [1:0] CMD_RELEASE = 2'd2;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_NONE = 2'd1;
    localparam logic [1:0] ST_NOT_IN_USE = 2'd2;

    typedef struct packed {
        logic capture;
        logic execute;
    } t_dp_cmd;

    typedef struct packed {
        logic init_busy;
    } t_dp_stat;

endpackage

// ===== design/fra_ctrl.sv =====
// Controller state machine that sequences capture, execution and result transfer.
`timescale 1ns / 1ps
module fra_ctrl
    import fra_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_OUT = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd.capture = 1'b0;
        o_cmd.execute = 1'b0;
        o_in_ready = 1'b0;
        o_out_valid = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (!i_stat.init_busy) begin
                    o_in_ready = 1'b1;
                    if (i_in_valid) begin
                        o_cmd.capture = 1'b1;
                        n_state = S_EXEC;
                    end
                end
            end
            S_EXEC: begin
                o_cmd.execute = 1'b1;
                n_state = S_OUT;
            end
            S_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== design/fra_datapath.sv =====
// Datapath with the free-handle queue memory, pointers, in-use map and fresh counter.
`timescale 1ns / 1ps
module fra_datapath
    import fra_pkg::*;
#(
    parameter int POOL_SIZE = 256
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_dp_cmd             i_cmd,
    output t_dp_stat            o_stat,
    input  logic [1:0]          i_op,
    input  logic [HANDLE_W-1:0] i_handle,
    output logic [HANDLE_W-1:0] o_handle,
    output logic [1:0]          o_status
);

    localparam int ISSUE_LIMIT = (POOL_SIZE < HANDLE_SPACE) ? POOL_SIZE : HANDLE_SPACE;
    localparam logic [COUNT_W-1:0] LIMIT = COUNT_W'(ISSUE_LIMIT);
    localparam logic [COUNT_W-1:0] FULL = COUNT_W'(HANDLE_SPACE);

    logic [HANDLE_W-1:0] r_mem [HANDLE_SPACE];
    logic                r_use_mem [HANDLE_SPACE];
    logic [HANDLE_W-1:0] r_rd_data;
    logic                r_use_rd;
    logic [1:0]          r_op;
    logic [HANDLE_W-1:0] r_hin;
    logic [HANDLE_W-1:0] r_head;
    logic [HANDLE_W-1:0] r_tail;
    logic [COUNT_W-1:0]  r_count;
    logic [COUNT_W-1:0]  r_fresh;
    logic                r_init_busy;
    logic [HANDLE_W-1:0] r_init_addr;
    logic [HANDLE_W-1:0] r_handle_out;
    logic [1:0]          r_status_out;

    logic                w_pop;
    logic                w_push;
    logic                w_fresh;
    logic                w_clear;
    logic [HANDLE_W-1:0] w_handle;
    logic [1:0]          w_status;
    logic                w_empty;
    logic                w_use_we;
    logic [HANDLE_W-1:0] w_use_addr;
    logic                w_use_bit;

    assign w_empty = (r_count == '0);
    assign w_use_we = w_pop | w_fresh | w_clear;
    assign o_stat.init_busy = r_init_busy;
    assign o_handle = r_handle_out;
    assign o_status = r_status_out;

    always_comb begin
        w_pop = 1'b0;
        w_push = 1'b0;
        w_fresh = 1'b0;
        w_clear = 1'b0;
        w_handle = '0;
        w_status = ST_NONE;
        w_use_addr = r_hin;
        w_use_bit = 1'b0;
        unique case (r_op)
            CMD_ALLOC: begin
                if (!w_empty) begin
                    w_pop = 1'b1;
                    w_handle = r_rd_data;
                    w_status = ST_OK;
                    w_use_addr = r_rd_data;
                    w_use_bit = 1'b1;
                end else if (r_fresh < LIMIT) begin
                    w_fresh = 1'b1;
                    w_handle = r_fresh[HANDLE_W-1:0];
                    w_status = ST_OK;
                    w_use_addr = r_fresh[HANDLE_W-1:0];
                    w_use_bit = 1'b1;
                end
            end
            CMD_TRY_ALLOC: begin
                if (!w_empty) begin
                    w_pop = 1'b1;
                    w_handle = r_rd_data;
                    w_status = ST_OK;
                    w_use_addr = r_rd_data;
                    w_use_bit = 1'b1;
                end
            end
            CMD_RELEASE: begin
                if (!r_use_rd) begin
                    w_status = ST_NOT_IN_USE;
                end else begin
                    w_clear = 1'b1;
                    w_push = (r_count < FULL);
                    w_status = ST_OK;
                end
            end
            CMD_UNUSED: begin
                w_status = ST_NONE;
            end
            default: begin
                w_status = ST_NONE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[r_head];
        if (i_cmd.execute && w_push) begin
            r_mem[r_tail] <= r_hin;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_use_rd <= r_use_mem[i_handle];
        end
        if (r_init_busy) begin
            r_use_mem[r_init_addr] <= 1'b0;
        end else if (i_cmd.execute && w_use_we) begin
            r_use_mem[w_use_addr] <= w_use_bit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init_busy <= 1'b1;
            r_init_addr <= '0;
        end else if (r_init_busy) begin
            r_init_addr <= r_init_addr + 1'b1;
            if (r_init_addr == '1) begin
                r_init_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op <= i_op;
            r_hin <= i_handle;
        end
        if (i_cmd.execute) begin
            r_handle_out <= w_handle;
            r_status_out <= w_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_tail <= '0;
            r_count <= '0;
            r_fresh <= '0;
        end else if (i_cmd.execute) begin
            if (w_pop) begin
                r_head <= r_head + 1'b1;
                r_count <= r_count - 1'b1;
            end
            if (w_fresh) begin
                r_fresh <= r_fresh + 1'b1;
            end
            if (w_push) begin
                r_tail <= r_tail + 1'b1;
                r_count <= r_count + 1'b1;
            end
        end
    end

endmodule

// ===== design/fifo_recycling_handle_allocator.sv =====
// Top level of the FIFO-recycling handle allocator.
//
// The block hands out 8-bit handles. A command arrives on the slave stream:
// tuser carries the command (allocate, try-allocate, release) and tdata the
// handle to release. Each command gives exactly one result on the master
// stream: tdata carries the granted handle and tuser the status.
// Allocate takes the oldest released handle from the free queue, or else a
// fresh handle from a counter until the issue limit min(POOL_SIZE, 256) is
// reached. Try-allocate grants only from the queue. Release of a handle that
// is not in use reports an error and changes nothing.
// One command is handled at a time: it is captured in the idle state, executed
// in the next cycle in the execute state, and its result is then offered from
// the output state. The free queue and the in-use map are read through
// registers ahead of execution, and the next command is taken only after
// the result transfer completes, so a stalled receiver holds the result and
// the slave side stays not ready.
// Reset clears the queue pointers and the counters at once. The in-use map is
// then cleared one entry per cycle, so the slave side stays not ready after
// reset until every entry is cleared; the queue memory needs no clearing
// because an entry is read only after it was written.
`timescale 1ns / 1ps
module fifo_recycling_handle_allocator
    import fra_pkg::*;
#(
    parameter int POOL_SIZE = 256
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,  // [7:0] handle_in
    input  logic [1:0] s_axis_tuser,  // [1:0] cmd
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,  // [7:0] handle_out
    output logic [1:0] m_axis_tuser   // [1:0] status
);

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    fra_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    fra_datapath #(
        .POOL_SIZE (POOL_SIZE)
    ) u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (w_cmd),
        .o_stat   (w_stat),
        .i_op     (s_axis_tuser),
        .i_handle (s_axis_tdata),
        .o_handle (m_axis_tdata),
        .o_status (m_axis_tuser)
    );

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the FIFO-recycling handle allocator.
`timescale 1ns / 1ps
module tb_top;
    import fra_pkg::*;

    localparam int POOL_SIZE = 256;
    localparam int ITEMS_PER_PHASE = 600;
    localparam int SEGMENT_LEN = 100;
    localparam int LONG_HOLD = 300;
    localparam int DRAIN_CYCLES = 10;
    localparam int CYCLE_LIMIT = 200000;

    typedef struct packed {
        logic [7:0] handle;
        logic [1:0] status;
    } t_alloc_result;

    class handle_pool_checker;
        logic [7:0] free_fifo[$];
        bit in_use[HANDLE_SPACE];
        int unsigned fresh_issued;
        int unsigned issue_limit;
        t_alloc_result expected_q[$];
        int unsigned failures;
        int unsigned grants;
        int unsigned refusals;
        int unsigned bad_releases;
        int unsigned exhausted;

        function new(int unsigned pool_size);
            issue_limit = (pool_size < HANDLE_SPACE) ? pool_size : HANDLE_SPACE;
            fresh_issued = 0;
            failures = 0;
            grants = 0;
            refusals = 0;
            bad_releases = 0;
            exhausted = 0;
            foreach (in_use[i]) in_use[i] = 1'b0;
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction

        function bit pick_in_use(output logic [7:0] h);
            int unsigned start;
            start = $urandom_range(HANDLE_SPACE - 1);
            h = '0;
            for (int i = 0; i < HANDLE_SPACE; i++) begin
                if (in_use[(start + i) % HANDLE_SPACE]) begin
                    h = 8'((start + i) % HANDLE_SPACE);
                    return 1'b1;
                end
            end
            return 1'b0;
        endfunction

        function void note_command(logic [1:0] cmd, logic [7:0] h);
            t_alloc_result r;
            r.handle = '0;
            r.status = ST_NONE;
            case (cmd)
                CMD_ALLOC, CMD_TRY_ALLOC: begin
                    if (free_fifo.size() != 0) begin
                        r.handle = free_fifo.pop_front();
                        in_use[r.handle] = 1'b1;
                        r.status = ST_OK;
                    end else if (cmd == CMD_ALLOC && fresh_issued < issue_limit) begin
                        r.handle = 8'(fresh_issued);
                        in_use[r.handle] = 1'b1;
                        fresh_issued++;
                        r.status = ST_OK;
                    end else if (cmd == CMD_ALLOC) begin
                        exhausted++;
                    end
                end
                CMD_RELEASE: begin
                    if (!in_use[h]) begin
                        r.status = ST_NOT_IN_USE;
                    end else begin
                        in_use[h] = 1'b0;
                        if (free_fifo.size() < HANDLE_SPACE) free_fifo.push_back(h);
                        r.status = ST_OK;
                    end
                end
                default: ;
            endcase
            if (r.status == ST_OK) grants++;
            else if (r.status == ST_NONE) refusals++;
            else bad_releases++;
            expected_q.push_back(r);
        endfunction

        function void check_result(logic [7:0] handle_out, logic [1:0] status);
            t_alloc_result e;
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected result, expected none, got handle %0d status %0d",
                         $time, handle_out, status);
                failures++;
                return;
            end
            e = expected_q.pop_front();
            if (handle_out !== e.handle) begin
                $display("%0t: handle_out mismatch, expected %0d, got %0d",
                         $time, e.handle, handle_out);
                failures++;
            end
            if (status !== e.status) begin
                $display("%0t: status mismatch, expected %0d, got %0d",
                         $time, e.status, status);
                failures++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [7:0] s_axis_tdata = '0;   // [7:0] handle_in
    logic [1:0] s_axis_tuser = '0;   // [1:0] cmd
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;        // [7:0] handle_out
    logic [1:0] m_axis_tuser;        // [1:0] status

    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    bit hold_request = 1'b0;
    int unsigned hold_count = 0;
    int unsigned cycle_count = 0;
    int unsigned items_sent = 0;

    handle_pool_checker pool = new(POOL_SIZE);

    fifo_recycling_handle_allocator #(
        .POOL_SIZE(POOL_SIZE)
    ) DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (hold_request && hold_count < LONG_HOLD) begin
            m_axis_tready <= 1'b0;
            hold_count <= hold_count + 1;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            pool.check_result(m_axis_tdata, m_axis_tuser);
        end
    end

    task automatic send_cmd(input logic [1:0] cmd, input logic [7:0] h);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= cmd;
        s_axis_tdata <= h;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        pool.note_command(cmd, h);
        items_sent++;
    endtask

    task automatic wait_all_results();
        s_axis_tvalid <= 1'b0;
        while (pool.pending() != 0) @(posedge i_clk);
    endtask

    // Segments alternate between growing and shrinking the set of live handles,
    // so the pool runs dry and the free queue fills and empties repeatedly.
    task automatic next_cmd(input bit grow, output logic [1:0] cmd, output logic [7:0] h);
        int unsigned r;
        r = $urandom_range(99);
        h = 8'($urandom_range(255));
        if (r < (grow ? 60 : 15)) begin
            cmd = CMD_ALLOC;
        end else if (r < (grow ? 70 : 35)) begin
            cmd = CMD_TRY_ALLOC;
        end else if (r < 85) begin
            cmd = CMD_RELEASE;
            void'(pool.pick_in_use(h));
        end else if (r < 95) begin
            cmd = CMD_RELEASE;
        end else begin
            cmd = CMD_UNUSED;
        end
    endtask

    initial begin
        logic [1:0] cmd;
        logic [7:0] h;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_cmd(CMD_UNUSED, 8'hFF);
        send_cmd(CMD_TRY_ALLOC, 8'h00);
        send_cmd(CMD_RELEASE, 8'h00);
        send_cmd(CMD_RELEASE, 8'hFF);
        send_cmd(CMD_ALLOC, 8'hFF);
        send_cmd(CMD_ALLOC, 8'h55);
        send_cmd(CMD_ALLOC, 8'hAA);
        send_cmd(CMD_RELEASE, 8'h01);
        send_cmd(CMD_RELEASE, 8'h01);
        send_cmd(CMD_RELEASE, 8'h00);
        send_cmd(CMD_TRY_ALLOC, 8'hFF);
        send_cmd(CMD_ALLOC, 8'h00);
        send_cmd(CMD_TRY_ALLOC, 8'h00);
        send_cmd(CMD_ALLOC, 8'h80);
        send_cmd(CMD_RELEASE, 8'h02);
        send_cmd(CMD_RELEASE, 8'h03);
        send_cmd(CMD_RELEASE, 8'h04);
        send_cmd(CMD_UNUSED, 8'h00);
        send_cmd(CMD_ALLOC, 8'h7F);
        send_cmd(CMD_TRY_ALLOC, 8'hFE);
        send_cmd(CMD_TRY_ALLOC, 8'h01);
        wait_all_results();

        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct = 22;
                    recv_stall_pct = 70;
                end
                1: begin
                    send_idle_pct = 70;
                    recv_stall_pct = 22;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                    hold_request = 1'b1;
                end
            endcase
            for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
                next_cmd(((i / SEGMENT_LEN) % 2) == 0, cmd, h);
                send_cmd(cmd, h);
            end
            wait_all_results();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (pool.pending() != 0) begin
            $display("%0t: %0d results never arrived", $time, pool.pending());
            pool.failures++;
        end

        $display("Ran %0d commands: %0d granted or released, %0d refused, %0d bad releases.",
                 items_sent, pool.grants, pool.refusals, pool.bad_releases);
        $display("Allocate hit an exhausted pool %0d times; %0d fresh handles were issued.",
                 pool.exhausted, pool.fresh_issued);
        if (pool.failures == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
